[hw/rtl/lcu_pkg.sv]
// Shared types and constants for the LFU cache table unit.
package lcu_pkg;

  // Field widths of one cache word.
  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned StampW = 48;

  // Configuration register file.
  localparam int unsigned CapW     = 5;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  // Use counts stop at the largest count value.
  localparam logic [CountW-1:0] CountMax = '1;

  // Register indexes, taken from paddr[2].
  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_e;

  // Operation codes of a request word.
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } opcode_e;

  // One stored cache entry.
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   value;
    logic [CountW-1:0] use_count;
    logic [StampW-1:0] last_touch;
  } entry_t;

endpackage

[hw/rtl/lcu_req_if.sv]
// Request channel: operation, key and value with a valid/ready handshake.
interface lcu_req_if;
  logic                            valid;
  logic                            ready;
  lcu_pkg::opcode_e                opcode;
  logic signed [lcu_pkg::KeyW-1:0] lookup_key;
  logic signed [lcu_pkg::ValW-1:0] write_value;

  modport source (output valid, opcode, lookup_key, write_value, input ready);
  modport sink   (input valid, opcode, lookup_key, write_value, output ready);
endinterface

[hw/rtl/lcu_rsp_if.sv]
// Response channel: hit flag, read value and eviction report.
interface lcu_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic signed [lcu_pkg::ValW-1:0] read_value;
  logic                            evicted;
  logic signed [lcu_pkg::KeyW-1:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

[hw/rtl/lfu_cache_table_unit.sv]
// LFU cache table with LRU tie-break, built around one entry memory.
//
//   channel   direction  handshake             contents
//   req_i     in         valid/ready           opcode, lookup_key, write_value
//   rsp_o     out        valid/ready           hit, read_value, evicted, evicted_key
//   APB       in/out     psel/penable/pready   capacity at byte address 0
//
// A word passes the scan, drain and commit states from acceptance to the next one:
// the entry memory is read one slot per cycle for the key match, the victim and
// the first free slot, then the commit state writes the chosen entry back.
// With capacity zero a word goes straight to commit and the memory is not touched.
// Reset clears the per-slot valid flags and the occupancy count at once, so no
// clearing pass runs. A stalled response holds the final write-back only; the
// next word is accepted while an earlier response still waits.
module lfu_cache_table_unit #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lcu_req_if.sink                         req_i,
  lcu_rsp_if.source                       rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lcu_pkg::AddrW-1:0]       paddr,
  input  logic [lcu_pkg::DataW-1:0]       pwdata,
  output logic [lcu_pkg::DataW-1:0]       prdata,
  output logic                            pready
);

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned OccW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (OccW > lcu_pkg::CapW) ? OccW : lcu_pkg::CapW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  // Control state.
  state_e                      state_q;
  logic [lcu_pkg::CapW-1:0]    cap_q;
  logic [MAX_ENTRIES-1:0]      valid_q;
  logic [OccW-1:0]             occ_q;
  logic [lcu_pkg::StampW-1:0]  touch_q;
  logic [IdxW-1:0]             addr_q;
  logic [IdxW-1:0]             rd_idx_q;
  logic                        rd_vld_q;
  logic                        off_q;

  // Captured request word.
  lcu_pkg::opcode_e            op_q;
  logic [lcu_pkg::KeyW-1:0]    key_q;
  logic [lcu_pkg::ValW-1:0]    val_q;

  // Scan results.
  logic                        match_q;
  logic [IdxW-1:0]             match_idx_q;
  lcu_pkg::entry_t             match_ent_q;
  logic                        vic_found_q;
  logic [IdxW-1:0]             vic_idx_q;
  logic [lcu_pkg::KeyW-1:0]    vic_key_q;
  logic [lcu_pkg::CountW-1:0]  vic_cnt_q;
  logic [lcu_pkg::StampW-1:0]  vic_stamp_q;
  logic                        free_found_q;
  logic [IdxW-1:0]             free_idx_q;

  // Response register.
  logic                        rsp_valid_q;
  logic                        rsp_hit_q;
  logic [lcu_pkg::ValW-1:0]    rsp_val_q;
  logic                        rsp_ev_q;
  logic [lcu_pkg::KeyW-1:0]    rsp_evk_q;

  // Entry memory with a registered read port.
  lcu_pkg::entry_t             mem [MAX_ENTRIES];
  lcu_pkg::entry_t             rd_q;
  logic                        mem_we;
  logic [IdxW-1:0]             mem_waddr;
  lcu_pkg::entry_t             mem_wdata;

  // Handshake and commit decisions.
  logic                        req_fire;
  logic                        cfg_write;
  logic                        commit;
  logic [CmpW-1:0]             cap_eff;
  logic                        need_evict;
  logic                        slot_live;
  logic                        key_eq;
  logic                        vic_better;
  logic                        res_hit;
  logic [lcu_pkg::ValW-1:0]    res_val;
  logic                        res_ev;
  logic [lcu_pkg::KeyW-1:0]    res_evk;
  logic                        ins_new;

  assign req_fire  = req_i.valid && req_i.ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign commit    = (state_q == ST_COMMIT) && (!rsp_valid_q || rsp_o.ready);

  // Capacity above the table depth acts as the table depth.
  always_comb begin
    if (CmpW'(cap_q) > CmpW'(MAX_ENTRIES)) begin
      cap_eff = CmpW'(MAX_ENTRIES);
    end else begin
      cap_eff = CmpW'(cap_q);
    end
  end
  assign need_evict = CmpW'(occ_q) >= cap_eff;

  // Per-slot comparisons on the word read in the previous cycle.
  assign slot_live  = rd_vld_q && valid_q[rd_idx_q];
  assign key_eq     = rd_q.key == key_q;
  assign vic_better = !vic_found_q || (rd_q.use_count < vic_cnt_q) ||
                      ((rd_q.use_count == vic_cnt_q) && (rd_q.last_touch < vic_stamp_q));

  // Result word and memory write for the commit cycle.
  always_comb begin
    res_hit   = 1'b0;
    res_val   = '1;
    res_ev    = 1'b0;
    res_evk   = '0;
    ins_new   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = match_idx_q;
    mem_wdata = match_ent_q;
    if (!off_q) begin
      if (match_q) begin
        // Hit: refresh the entry, overwrite the value on a put.
        res_hit = 1'b1;
        if (op_q == lcu_pkg::OP_GET) begin
          res_val = match_ent_q.value;
        end else begin
          mem_wdata.value = val_q;
        end
        if (match_ent_q.use_count != lcu_pkg::CountMax) begin
          mem_wdata.use_count = match_ent_q.use_count + 1'b1;
        end
        mem_wdata.last_touch = touch_q;
        mem_we = 1'b1;
      end else if (op_q == lcu_pkg::OP_PUT) begin
        // Miss on a put: reuse the victim when full, else the first free slot.
        mem_wdata.key        = key_q;
        mem_wdata.value      = val_q;
        mem_wdata.use_count  = lcu_pkg::CountW'(1);
        mem_wdata.last_touch = touch_q;
        if (need_evict) begin
          res_ev    = vic_found_q;
          res_evk   = vic_found_q ? vic_key_q : '0;
          mem_waddr = vic_idx_q;
          mem_we    = vic_found_q;
        end else begin
          mem_waddr = free_idx_q;
          mem_we    = free_found_q;
          ins_new   = free_found_q;
        end
      end
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we && commit) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[addr_q];
  end

  // Sequencer, scan trackers and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cap_q        <= lcu_pkg::CapReset;
      valid_q      <= '0;
      occ_q        <= '0;
      touch_q      <= '0;
      addr_q       <= '0;
      rd_idx_q     <= '0;
      rd_vld_q     <= 1'b0;
      off_q        <= 1'b0;
      op_q         <= lcu_pkg::OP_GET;
      key_q        <= '0;
      val_q        <= '0;
      match_q      <= 1'b0;
      match_idx_q  <= '0;
      match_ent_q  <= '0;
      vic_found_q  <= 1'b0;
      vic_idx_q    <= '0;
      vic_key_q    <= '0;
      vic_cnt_q    <= '0;
      vic_stamp_q  <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_hit_q    <= 1'b0;
      rsp_val_q    <= '0;
      rsp_ev_q     <= 1'b0;
      rsp_evk_q    <= '0;
    end else begin
      // Configuration write.
      if (cfg_write && (lcu_pkg::reg_idx_e'(paddr[2]) == lcu_pkg::REG_CAPACITY)) begin
        cap_q <= pwdata[lcu_pkg::CapW-1:0];
      end

      // Response register drains on its handshake unless a new word lands.
      if (rsp_o.ready && !commit) begin
        rsp_valid_q <= 1'b0;
      end

      rd_idx_q <= addr_q;
      rd_vld_q <= (state_q == ST_SCAN);

      // Track the matching key, the victim and the first free slot.
      if (slot_live) begin
        if (key_eq && !match_q) begin
          match_q     <= 1'b1;
          match_idx_q <= rd_idx_q;
          match_ent_q <= rd_q;
        end
        if (vic_better) begin
          vic_found_q <= 1'b1;
          vic_idx_q   <= rd_idx_q;
          vic_key_q   <= rd_q.key;
          vic_cnt_q   <= rd_q.use_count;
          vic_stamp_q <= rd_q.last_touch;
        end
      end else if (rd_vld_q && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= rd_idx_q;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            op_q         <= req_i.opcode;
            key_q        <= req_i.lookup_key;
            val_q        <= req_i.write_value;
            off_q        <= (cap_q == '0);
            match_q      <= 1'b0;
            vic_found_q  <= 1'b0;
            free_found_q <= 1'b0;
            addr_q       <= '0;
            state_q      <= (cap_q == '0) ? ST_COMMIT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (addr_q == LastIdx) begin
            state_q <= ST_DRAIN;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (commit) begin
            rsp_valid_q <= 1'b1;
            rsp_hit_q   <= res_hit;
            rsp_val_q   <= res_val;
            rsp_ev_q    <= res_ev;
            rsp_evk_q   <= res_evk;
            if (mem_we) begin
              touch_q <= touch_q + 1'b1;
            end
            if (ins_new) begin
              valid_q[mem_waddr] <= 1'b1;
              occ_q              <= occ_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Channel outputs.
  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.hit         = rsp_hit_q;
  assign rsp_o.read_value  = rsp_val_q;
  assign rsp_o.evicted     = rsp_ev_q;
  assign rsp_o.evicted_key = rsp_evk_q;

  // Register read-back.
  assign pready = 1'b1;
  always_comb begin
    unique case (lcu_pkg::reg_idx_e'(paddr[2]))
      lcu_pkg::REG_CAPACITY: prdata = lcu_pkg::DataW'(cap_q);
      default:               prdata = '0;
    endcase
  end

endmodule
